@@ rtl/ccdgm_pkg.sv @@
// Shared types and constants for the CCD line gap measure unit.
// No dependencies; used by ccdgm_div and ccd_line_gap_measure_unit.
package ccdgm_pkg;

  // Signed pixel index wide enough for every search and window position
  localparam int unsigned IDX_W = 14;
  typedef logic signed [IDX_W-1:0] idx_t;

  // Divider widths: smoothing sum plus rounding term, normalizing divisor
  localparam int unsigned DVD_W = 20;
  localparam int unsigned DVS_W = 12;

  // Configuration register indexes
  localparam logic [2:0] CFG_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_CALIB     = 3'd1;
  localparam logic [2:0] CFG_W_LOW     = 3'd2;
  localparam logic [2:0] CFG_W_HIGH    = 3'd3;
  localparam logic [2:0] CFG_NORM      = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NO_MAGNET = 2'd1;
  localparam logic [1:0] ST_NO_BALL   = 2'd2;

  // Search geometry
  localparam idx_t HALF_WIN   = 14'sd20;   // window reaches 20 pixels below the hit and 21 above
  localparam idx_t WIN_TAP0   = 14'sd27;   // first tap of first window entry: 20 + 7
  localparam idx_t TAP_REWIND = 14'sd13;   // back from last tap to next entry's first
  localparam idx_t FIR_HALF   = 14'sd7;
  localparam idx_t BALL_STEP  = 14'sd50;
  localparam idx_t BALL_LOW   = 14'sd28;   // lowest index the ball search visits
  localparam idx_t BALL_TAIL  = 14'sd78;   // below this a miss scans the line head
  localparam idx_t BALL_HEAD  = 14'sd77;
  localparam logic [5:0] WIN_LAST = 6'd41; // 42 smoothed entries
  localparam logic [3:0] TAP_LAST = 4'd14; // 15 taps

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
  } ccdgm_in_t;

  typedef struct packed {
    logic signed [15:0] gap_um;
    logic [1:0]         status;
  } ccdgm_out_t;

endpackage

@@ rtl/ccdgm_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ccdgm_pkg for operand widths.
module ccdgm_div
  import ccdgm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CW = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             run_q, done_q;
  logic [DVS_W:0]   trial, diff;
  logic             ge;

  // Shift in the next dividend bit and try to subtract
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= dividend_i;
        rem_q <= '0;
        dvs_q <= divisor_i;
        cnt_q <= CW'(DVD_W - 1);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], ge};
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ rtl/ccd_line_gap_measure_unit.sv @@
// Top level of the CCD line gap measure unit: line memory, smoothing memory
// and the edge search sequencer. Depends on ccdgm_pkg and ccdgm_div.
//
// Pixels are taken one per clock while busy is low; a pixel with line_end
// set starts the measurement and raises busy until the result strobe.
// The measurement is a sequencer around one synchronous line memory port:
// a line scan steps one pixel at a time and the ball search strides 50
// pixels; each of the 2 x 42 smoothed entries sums 15 taps and is
// normalized by the shared bit-serial divider, the fine scan steps through
// the smoothed entries and the interpolation uses the divider again. A line
// without a coarse magnet hit ends after the line scan. res_valid_o is high
// for one cycle per line and cannot be held off.
module ccd_line_gap_measure_unit
  import ccdgm_pkg::*;
#(
  parameter int unsigned LINE_PIXELS = 4096,
  parameter int unsigned SEARCH_SPAN = 300
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  ccdgm_in_t  item_i,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output logic       res_valid_o,
  output ccdgm_out_t res_o
);

  localparam int unsigned AW = $clog2(LINE_PIXELS);
  localparam idx_t LINE_LIM = idx_t'(LINE_PIXELS);
  localparam idx_t SPAN     = idx_t'(SEARCH_SPAN);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_EV  = 4'd2;
  localparam logic [3:0] S_SM_RD  = 4'd3;
  localparam logic [3:0] S_SM_EV  = 4'd4;
  localparam logic [3:0] S_SM_DIV = 4'd5;
  localparam logic [3:0] S_F_RD   = 4'd6;
  localparam logic [3:0] S_F_EV   = 4'd7;
  localparam logic [3:0] S_F_DIV  = 4'd8;
  localparam logic [3:0] S_B_TOP  = 4'd9;
  localparam logic [3:0] S_B_RD   = 4'd10;
  localparam logic [3:0] S_B_EV   = 4'd11;

  // Configuration
  logic [7:0]   thr_q;
  logic [11:0]  cal_q;
  logic [119:0] wts_q;
  logic [11:0]  norm_q;

  // Memories
  logic [7:0] line_mem [LINE_PIXELS];
  logic [7:0] sm_mem [64];
  logic [7:0] rd_q, sm_rd_q;
  logic       oor_q;

  // Sequencer state
  logic [3:0]    state_q;
  logic [AW-1:0] cnt_q;
  idx_t          idx_q, lo_q, b1_q, bi_q;
  logic [5:0]    k_q;
  logic [3:0]    tap_q;
  logic [DVD_W-1:0] sum_q;
  logic          first_q, ball_q, neg_q;
  logic [7:0]    yprev_q;
  logic signed [17:0] x1_q;
  logic          res_valid_q;
  ccdgm_out_t    res_q;

  logic accept;
  logic [7:0]  pv, wt, y;
  logic [15:0] prod;
  logic [DVD_W-1:0] sum_d;
  logic [11:0] nd, half;
  logic hit_line, hit_fine;
  logic signed [8:0]  dlt, dhalf, thr_y;
  logic signed [12:0] num;
  logic [11:0] num_mag;
  logic [7:0]  d_mag;
  logic signed [17:0] xq, x_fin, ibase;
  logic signed [18:0] gap_w;
  logic signed [15:0] gap_sat;
  logic fin_go, smooth_done;
  logic div_go;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic div_done;
  logic [7:0] sat_q8;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Line memory: write on pixel transfer, read at idx_q every cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[cnt_q] <= item_i.pixel;
    end
    rd_q  <= line_mem[idx_q[AW-1:0]];
    oor_q <= (idx_q < 0) || (idx_q >= LINE_LIM);
  end

  // Smoothing memory: write when a normalized entry is ready, read at k_q
  always_ff @(posedge clk_i) begin
    if (smooth_done) begin
      sm_mem[k_q] <= sat_q8;
    end
    sm_rd_q <= sm_mem[k_q];
  end

  // Datapath terms
  assign pv       = oor_q ? 8'd0 : rd_q;
  assign wt       = wts_q[{tap_q, 3'b000} +: 8];
  assign prod     = wt * pv;
  assign sum_d    = sum_q + DVD_W'(prod);
  assign nd       = (norm_q == '0) ? 12'd1 : norm_q;
  assign half     = nd >> 1;
  assign hit_line = ball_q ? (pv > thr_q) : (pv < thr_q);
  assign y        = sm_rd_q;
  assign hit_fine = ball_q ? (y > thr_q) : (y < thr_q);
  assign sat_q8   = (|div_q[DVD_W-1:8]) ? 8'hFF : div_q[7:0];
  assign smooth_done = (state_q == S_SM_DIV) && div_done;

  // Interpolation terms, truncating toward zero as signed division does
  assign dlt     = $signed({1'b0, yprev_q}) - $signed({1'b0, y});
  assign dhalf   = dlt[8] ? -((-dlt) >>> 1) : (dlt >>> 1);
  assign thr_y   = $signed({1'b0, thr_q}) - $signed({1'b0, y});
  assign num     = ($signed({{4{thr_y[8]}}, thr_y}) <<< 3) + $signed({{4{dhalf[8]}}, dhalf});
  assign num_mag = num[12] ? 12'(-num) : num[11:0];
  assign d_mag   = dlt[8] ? 8'(-dlt) : dlt[7:0];

  // Finished crossing position
  assign ibase  = $signed({{4{b1_q[IDX_W-1]}}, b1_q}) + 18'sd0
                  + $signed({12'd0, k_q});
  assign xq     = (state_q == S_F_DIV)
                  ? (neg_q ? -$signed({6'd0, div_q[11:0]}) : $signed({6'd0, div_q[11:0]}))
                  : 18'sd4;
  assign x_fin  = (ibase <<< 3) + xq;
  assign fin_go = ((state_q == S_F_DIV) && div_done) ||
                  ((state_q == S_F_EV) && !first_q && hit_fine && (dlt == '0));
  assign gap_w  = $signed({x1_q[17], x1_q}) - $signed({x_fin[17], x_fin});
  assign gap_sat = (gap_w > 19'sd32767) ? 16'sh7FFF :
                   (gap_w < -19'sd32768) ? 16'sh8000 : gap_w[15:0];

  // Shared divider launch
  always_comb begin
    div_go  = 1'b0;
    div_dvd = sum_d;
    div_dvs = nd;
    if ((state_q == S_SM_EV) && (tap_q == TAP_LAST)) begin
      div_go = 1'b1;
    end else if ((state_q == S_F_EV) && !first_q && hit_fine && (dlt != '0)) begin
      div_go  = 1'b1;
      div_dvd = DVD_W'(num_mag);
      div_dvs = DVS_W'(d_mag);
    end
  end

  ccdgm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= 8'd128;
      cal_q  <= 12'd2000;
      wts_q  <= '0;
      norm_q <= 12'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: thr_q <= cfg_wdata_i[7:0];
        CFG_CALIB:     cal_q <= cfg_wdata_i[11:0];
        CFG_W_LOW:     wts_q[63:0] <= cfg_wdata_i;
        CFG_W_HIGH:    wts_q[119:64] <= cfg_wdata_i[55:0];
        CFG_NORM:      norm_q <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      idx_q       <= '0;
      lo_q        <= '0;
      b1_q        <= '0;
      bi_q        <= '0;
      k_q         <= '0;
      tap_q       <= '0;
      sum_q       <= '0;
      first_q     <= 1'b0;
      ball_q      <= 1'b0;
      neg_q       <= 1'b0;
      yprev_q     <= '0;
      x1_q        <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (item_i.line_end) begin
              cnt_q   <= '0;
              ball_q  <= 1'b0;
              idx_q   <= idx_t'({2'b00, cal_q}) + SPAN;
              lo_q    <= idx_t'({2'b00, cal_q}) + 14'sd1;
              state_q <= S_SC_RD;
            end else if (cnt_q == AW'(LINE_PIXELS - 1)) begin
              cnt_q <= '0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_SC_RD: state_q <= S_SC_EV;
        S_SC_EV: begin
          // Line scan downward: hit opens a window, running out fails
          if (hit_line) begin
            b1_q    <= idx_q - HALF_WIN;
            idx_q   <= idx_q - WIN_TAP0;
            k_q     <= '0;
            tap_q   <= '0;
            sum_q   <= DVD_W'(half);
            state_q <= S_SM_RD;
          end else if (idx_q == lo_q) begin
            res_valid_q   <= 1'b1;
            res_q.status  <= ball_q ? ST_NO_BALL : ST_NO_MAGNET;
            res_q.gap_um  <= ball_q ? $signed({4'd0, cal_q}) : 16'sd0;
            state_q       <= S_IDLE;
          end else begin
            idx_q   <= idx_q - 14'sd1;
            state_q <= S_SC_RD;
          end
        end
        S_SM_RD: state_q <= S_SM_EV;
        S_SM_EV: begin
          // Accumulate one tap
          sum_q <= sum_d;
          if (tap_q == TAP_LAST) begin
            state_q <= S_SM_DIV;
          end else begin
            tap_q   <= tap_q + 1'b1;
            idx_q   <= idx_q + 14'sd1;
            state_q <= S_SM_RD;
          end
        end
        S_SM_DIV: begin
          if (div_done) begin
            if (k_q == WIN_LAST) begin
              first_q <= 1'b1;
              state_q <= S_F_RD;
            end else begin
              k_q     <= k_q + 1'b1;
              tap_q   <= '0;
              sum_q   <= DVD_W'(half);
              idx_q   <= idx_q - TAP_REWIND;
              state_q <= S_SM_RD;
            end
          end
        end
        S_F_RD: state_q <= S_F_EV;
        S_F_EV: begin
          // Fine scan from the window top down
          if (first_q) begin
            first_q <= 1'b0;
            yprev_q <= y;
            k_q     <= k_q - 1'b1;
            state_q <= S_F_RD;
          end else if (hit_fine) begin
            neg_q <= num[12] ^ dlt[8];
            if (dlt != '0) begin
              state_q <= S_F_DIV;
            end
          end else if (k_q == '0) begin
            res_valid_q  <= 1'b1;
            res_q.status <= ball_q ? ST_NO_BALL : ST_NO_MAGNET;
            res_q.gap_um <= ball_q ? $signed({4'd0, cal_q}) : 16'sd0;
            state_q      <= S_IDLE;
          end else begin
            yprev_q <= y;
            k_q     <= k_q - 1'b1;
            state_q <= S_F_RD;
          end
        end
        S_F_DIV: ;
        S_B_TOP: begin
          // Coarse ball stride, or reuse the magnet window near line start
          if (bi_q >= BALL_LOW) begin
            idx_q   <= bi_q;
            state_q <= S_B_RD;
          end else begin
            idx_q   <= b1_q - FIR_HALF;
            k_q     <= '0;
            tap_q   <= '0;
            sum_q   <= DVD_W'(half);
            state_q <= S_SM_RD;
          end
        end
        S_B_RD: state_q <= S_B_EV;
        S_B_EV: begin
          if (pv > thr_q) begin
            idx_q   <= bi_q + BALL_STEP;
            lo_q    <= bi_q;
            state_q <= S_SC_RD;
          end else if (bi_q < BALL_TAIL) begin
            idx_q   <= BALL_HEAD;
            lo_q    <= BALL_LOW;
            state_q <= S_SC_RD;
          end else begin
            bi_q    <= bi_q - BALL_STEP;
            state_q <= S_B_TOP;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Crossing found: keep magnet position or emit the gap
      if (fin_go) begin
        if (!ball_q) begin
          x1_q    <= x_fin;
          bi_q    <= b1_q - 14'sd1;
          ball_q  <= 1'b1;
          state_q <= S_B_TOP;
        end else begin
          res_valid_q  <= 1'b1;
          res_q.status <= ST_FOUND;
          res_q.gap_um <= gap_sat;
          state_q      <= S_IDLE;
        end
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
